// ===== hdl/vxlan_outer_header_builder_unit_assert.svh =====
// assertion macros for the header builder
`ifndef VXLAN_OUTER_HEADER_BUILDER_UNIT_ASSERT_SVH
`define VXLAN_OUTER_HEADER_BUILDER_UNIT_ASSERT_SVH
// implication checked on every clock edge outside reset
`define VOHB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
else $error("assertion failed");
// implication checked in the cycle after the antecedent
`define VOHB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
else $error("assertion failed");
`endif

// ===== hdl/vohb_pkg.sv =====
`default_nettype none
package vohb_pkg;
	localparam int TableDepthDef = 64;
	localparam logic [31:0] CrcPoly = 32'h82F63B78;
	localparam logic [15:0] PortBase = 16'd49152;
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_FREE = 2'd1;
	localparam logic [1:0] OP_ENCAP = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [2:0] HdrWords = 3'd7;

	typedef struct packed {
		logic [1:0]  op;
		logic [5:0]  index;
		logic [47:0] dst_mac;
		logic [47:0] src_mac;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [23:0] vni;
		logic [15:0] udp_port;
		logic [15:0] inner_length;
		logic [15:0] inner_type;
	} req_t;

	typedef struct packed {
		logic [63:0] word;
		logic [3:0]  bytes_valid;
		logic        last;
		logic        status;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_READ, ST_CRC, ST_SUM, ST_EMIT, ST_STAT
	} state_t;
endpackage
`default_nettype wire

// ===== hdl/vxlan_outer_header_builder_unit.sv =====
// channel   | direction | payload | handshake
// in        | input     | req_t   | in_valid / in_stall
// out       | output    | rsp_t   | out_valid / out_stall
// write, free, encap miss: a read state, then one status request; unused op: no output
// encapsulate: a read state, then the crc steps over the twelve mac bytes (one crc
//   byte per cycle through the shared byte unit), the checksum adds of the nine ip
//   header words and a fold step, then 7 words, one per cycle when not stalled
// in_stall is high whenever an item is in flight; reset clears in-use marks
// and the sequencer, table payload is masked by the in-use bit
`default_nettype none
module vxlan_outer_header_builder_unit #(
	parameter int TABLE_DEPTH = vohb_pkg::TableDepthDef
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire vohb_pkg::req_t in_data,
	output logic                out_valid,
	input  wire logic           out_stall,
	output vohb_pkg::rsp_t      out_data
);
	import vohb_pkg::*;
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	// tunnel table memory, one wide row per entry
	logic [199:0] mem [TABLE_DEPTH];
	logic [199:0] row_q;
	logic [TABLE_DEPTH-1:0] used_q;
	req_t req_q;
	state_t state_q, state_d;
	logic [3:0] cnt_q;
	logic [31:0] crc_q;
	logic [16:0] sum_q;
	logic [2:0] wcnt_q;
	logic ok_q, hit_q, stat_q;
	logic [AW-1:0] idx;
	logic [AW-1:0] in_idx;
	logic in_range;
	logic [447:0] hdr;
	logic [7:0] crc_byte;
	logic [31:0] crc_nx;
	logic [15:0] sum_term;
	logic [15:0] tot_len, udp_len, sport;

	assign in_range = ({26'd0, in_data.index} < 32'(TABLE_DEPTH));
	assign in_idx = AW'(in_data.index);
	assign idx = AW'(req_q.index);

	// byte-wide crc32c step, shared over all twelve mac bytes
	always_comb begin
		logic [95:0] macs;
		macs = {req_q.dst_mac, req_q.src_mac};
		crc_byte = macs[8'(95 - 8*cnt_q) -: 8];
		crc_nx = crc_q ^ {24'd0, crc_byte};
		for (int k = 0; k < 8; k++)
			crc_nx = crc_nx[0] ? ((crc_nx >> 1) ^ CrcPoly) : (crc_nx >> 1);
	end

	assign tot_len = req_q.inner_length + 16'd36;
	assign udp_len = req_q.inner_length + 16'd16;
	assign sport = 16'(crc_q[31:18]) + PortBase;

	// ip header words, one fed to the adder per cycle (checksum left zero)
	always_comb begin
		case (cnt_q)
			4'd0: sum_term = 16'h4500;
			4'd1: sum_term = tot_len;
			4'd2: sum_term = 16'h0000;
			4'd3: sum_term = 16'h4000;
			4'd4: sum_term = 16'h4011;
			4'd5: sum_term = row_q[103:88];
			4'd6: sum_term = row_q[87:72];
			4'd7: sum_term = row_q[71:56];
			4'd8: sum_term = row_q[55:40];
			default: sum_term = 16'h0000;
		endcase
	end

	// row: dmac 199:152, smac 151:104, sip 103:72, dip 71:40, vni 39:16, port 15:0
	assign hdr = {row_q[199:104], 16'h0800, 16'h4500, tot_len, 16'h0000, 16'h4000,
		16'h4011, ~sum_q[15:0], row_q[103:40], sport, row_q[15:0], udp_len,
		16'h0000, 32'h08000000, row_q[39:16], 8'h00, 48'd0};

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_READ;
			ST_READ: begin
				if (req_q.op == OP_ENCAP && hit_q) state_d = ST_CRC;
				else if (req_q.op == OP_UNUSED) state_d = ST_IDLE;
				else state_d = ST_STAT;
			end
			ST_CRC: if (cnt_q == 4'd11) state_d = ST_SUM;
			ST_SUM: if (cnt_q == 4'd9) state_d = ST_EMIT;
			ST_EMIT: if (!out_stall && wcnt_q == HdrWords - 3'd1) state_d = ST_IDLE;
			ST_STAT: if (!out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != ST_IDLE);
		out_valid = (state_q == ST_EMIT) || (state_q == ST_STAT);
		out_data = '0;
		if (state_q == ST_STAT) begin
			out_data.last = 1'b1;
			out_data.status = stat_q;
		end else if (state_q == ST_EMIT) begin
			out_data.word = hdr[10'(447 - 64*wcnt_q) -: 64];
			out_data.bytes_valid = (wcnt_q == HdrWords - 3'd1) ? 4'd2 : 4'd8;
			out_data.last = (wcnt_q == HdrWords - 3'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			used_q <= '0;
			cnt_q <= '0;
			wcnt_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: cnt_q <= '0;
				ST_READ: begin
					cnt_q <= '0;
					if (ok_q && req_q.op == OP_WRITE) used_q[idx] <= 1'b1;
					if (hit_q && req_q.op == OP_FREE) used_q[idx] <= 1'b0;
				end
				ST_CRC: cnt_q <= (cnt_q == 4'd11) ? 4'd0 : cnt_q + 4'd1;
				ST_SUM: cnt_q <= cnt_q + 4'd1;
				// word counter wraps after the short final word
				ST_EMIT: if (!out_stall)
					wcnt_q <= (wcnt_q == HdrWords - 3'd1) ? 3'd0 : wcnt_q + 3'd1;
				default: wcnt_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				req_q <= in_data;
				ok_q <= in_range;
				hit_q <= in_range && used_q[in_idx];
				row_q <= mem[in_idx];
			end
			ST_READ: begin
				crc_q <= {16'd0, req_q.inner_type[7:0], req_q.inner_type[15:8]};
				sum_q <= '0;
				if (!used_q[idx]) row_q <= '0;
				stat_q <= (req_q.op == OP_WRITE) ? !ok_q : !hit_q;
				if (ok_q && req_q.op == OP_WRITE)
					mem[idx] <= {req_q.dst_mac, req_q.src_mac, req_q.src_ip,
						req_q.dst_ip, req_q.vni, req_q.udp_port};
			end
			ST_CRC: crc_q <= crc_nx;
			ST_SUM: begin
				// end-around carry fold each step
				if (cnt_q != 4'd9)
					sum_q <= {1'b0, 16'(sum_q[15:0] + sum_term + 16'(sum_q[16]))} +
						17'({16'd0, 1'b0}) + 17'(({1'b0, sum_q[15:0]} +
						{1'b0, sum_term} + 17'(sum_q[16])) >> 16);
				else
					sum_q <= {1'b0, 16'(sum_q[15:0] + 16'(sum_q[16]))};
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ===== hdl/vohb_checker.sv =====
`default_nettype none
`include "vxlan_outer_header_builder_unit_assert.svh"
module vohb_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           in_valid,
	input wire logic           in_stall,
	input wire logic           out_valid,
	input wire logic           out_stall,
	input wire vohb_pkg::rsp_t out_data
);
	// a status request carries an empty word
	`VOHB_ASSERT_IMP(a_stat_empty, clk, arst_n,
		out_valid && out_data.bytes_valid == 4'd0, out_data.word == 64'd0 && out_data.last)
	// the short final word is the last one
	`VOHB_ASSERT_IMP(a_short_last, clk, arst_n,
		out_valid && out_data.bytes_valid == 4'd2, out_data.last)
	// no new item while a result is offered
	`VOHB_ASSERT_IMP(a_busy, clk, arst_n, out_valid, in_stall)
	// an accepted request makes the block busy with nothing offered yet
	`VOHB_ASSERT_NEXT(a_take, clk, arst_n, in_valid && !in_stall, in_stall && !out_valid)
	// a stalled result holds
	`VOHB_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(out_data))
endmodule
bind vxlan_outer_header_builder_unit vohb_checker u_chk (.*);
`default_nettype wire
